FILE: rtl/ray_plane_acceptance_counter_top_defines.svh
// ----------------------------------------------------------------------------
// Ray-plane acceptance counter assertion macros
// Shared assertion forms for the acceptance counter RTL.
// ----------------------------------------------------------------------------
`ifndef RAY_PLANE_ACCEPTANCE_COUNTER_TOP_DEFINES_SVH
`define RAY_PLANE_ACCEPTANCE_COUNTER_TOP_DEFINES_SVH

// same-cycle implication
`define RPAC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rpac_pkg.sv
// ----------------------------------------------------------------------------
// Ray-plane acceptance counter package
// Register layout, geometry result type and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package rpac_pkg;

   localparam int unsigned CORDIC_STEPS   = 16;
   localparam int unsigned CORDIC_START   = 19898;
   localparam int unsigned OUTER_PATH_NUM = 64;
   localparam int unsigned OUTER_PATH_DEN = 25;

   localparam logic [2:0] CSR_SOURCE_X      = 3'd0;
   localparam logic [2:0] CSR_SOURCE_Y      = 3'd1;
   localparam logic [2:0] CSR_SOURCE_HEIGHT = 3'd2;
   localparam logic [2:0] CSR_OUTER_HALF_X  = 3'd3;
   localparam logic [2:0] CSR_OUTER_HALF_Y  = 3'd4;
   localparam logic [2:0] CSR_INNER_HALF_X  = 3'd5;
   localparam logic [2:0] CSR_INNER_HALF_Y  = 3'd6;
   localparam logic [2:0] CSR_INNER_MIN     = 3'd7;

   typedef struct packed {
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      logic [14:0]        source_height;
      logic [14:0]        outer_half_x;
      logic [14:0]        outer_half_y;
      logic [14:0]        inner_half_x;
      logic [14:0]        inner_half_y;
      logic [14:0]        inner_min_path;
   } csr_type;

   typedef struct packed {
      logic done;
      logic outer;
      logic inner;
   } geom_res_type;

   function automatic logic [13:0] atan_lookup(input logic [3:0] idx);
      logic [13:0] v;
      case (idx)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         4'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rpac_geom.sv
// ----------------------------------------------------------------------------
// Ray-plane acceptance counter geometry unit
// Bit-serial square root and CORDIC, then ray hit tests on the two rectangles.
// ----------------------------------------------------------------------------
`default_nettype none

module rpac_geom import rpac_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] cos_polar,
   input  wire logic signed [15:0] azimuth,
   input  wire csr_type            csr,
   output geom_res_type            res
);

   localparam logic [2:0] G_IDLE = 3'd0;
   localparam logic [2:0] G_ITER = 3'd1;
   localparam logic [2:0] G_MUL1 = 3'd2;
   localparam logic [2:0] G_MUL2 = 3'd3;
   localparam logic [2:0] G_CMP  = 3'd4;

   logic [2:0]         gst_ff, gst_in;
   logic [3:0]         step_ff;
   logic [30:0]        rem_ff;
   logic [31:0]        root_ff;
   logic [15:0]        m_ff;
   logic               neg_ff;
   logic signed [17:0] x_ff, y_ff;
   logic signed [16:0] z_ff;
   logic               flip_ff;
   logic signed [34:0] tx_ff, ty_ff;
   logic signed [32:0] sxm_ff, sym_ff;
   logic signed [50:0] xt_ff, yt_ff;
   logic [30:0]        ohx_ff, ohy_ff, ihx_ff, ihy_ff;
   logic               path_out_ff, path_in_ff;
   logic               done_ff, outer_ff, inner_ff;

   logic signed [31:0] csq;
   logic signed [16:0] c_ext, a_ext, c_neg;
   logic [4:0]         shamt;
   logic [31:0]        bit_v, trial;
   logic signed [17:0] dx, dy, co, si;
   logic signed [16:0] at;
   logic [15:0]        sn;
   logic [19:0]        h25;
   logic signed [51:0] xs, ys, ax, ay;

   assign csq   = cos_polar * cos_polar;
   assign c_ext = 17'(cos_polar);
   assign a_ext = 17'(azimuth);
   assign c_neg = -c_ext;
   assign shamt = 5'd30 - {step_ff, 1'b0};
   assign bit_v = 32'd1 << shamt;
   assign trial = root_ff + bit_v;
   assign dx    = y_ff >>> step_ff;
   assign dy    = x_ff >>> step_ff;
   assign at    = $signed({3'b000, atan_lookup(step_ff)});
   assign sn    = root_ff[15:0];
   assign co    = flip_ff ? -x_ff : x_ff;
   assign si    = flip_ff ? -y_ff : y_ff;
   assign h25   = 20'(csr.source_height) * 20'(OUTER_PATH_DEN);
   assign xs    = (52'(sxm_ff) <<< 15) + 52'(xt_ff);
   assign ys    = (52'(sym_ff) <<< 15) + 52'(yt_ff);
   assign ax    = xs[51] ? -xs : xs;
   assign ay    = ys[51] ? -ys : ys;

   always_comb begin
      gst_in = gst_ff;
      case (gst_ff)
         G_IDLE:  if (start) gst_in = G_ITER;
         G_ITER:  if (step_ff == 4'(CORDIC_STEPS - 1)) gst_in = G_MUL1;
         G_MUL1:  gst_in = G_MUL2;
         G_MUL2:  gst_in = G_CMP;
         G_CMP:   gst_in = G_IDLE;
         default: gst_in = G_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gst_ff  <= G_IDLE;
         step_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         gst_ff  <= gst_in;
         done_ff <= (gst_ff == G_CMP);
         if (gst_ff == G_ITER) step_ff <= step_ff + 4'd1;
         else step_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      case (gst_ff)
         G_IDLE: begin
            rem_ff  <= 31'(32'h4000_0000 - $unsigned(csq));
            root_ff <= '0;
            m_ff    <= c_neg[15:0];
            neg_ff  <= cos_polar[15];
            x_ff    <= 18'(CORDIC_START);
            y_ff    <= '0;
            if (a_ext > 17'sd16384) begin
               z_ff    <= a_ext - 17'sd32768;
               flip_ff <= 1'b1;
            end else if (a_ext < -17'sd16384) begin
               z_ff    <= a_ext + 17'sd32768;
               flip_ff <= 1'b1;
            end else begin
               z_ff    <= a_ext;
               flip_ff <= 1'b0;
            end
         end
         G_ITER: begin
            if ({1'b0, rem_ff} >= trial) begin
               rem_ff  <= 31'({1'b0, rem_ff} - trial);
               root_ff <= (root_ff >> 1) + bit_v;
            end else begin
               root_ff <= root_ff >> 1;
            end
            if (z_ff >= 0) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
         end
         G_MUL1: begin
            tx_ff  <= $signed({1'b0, sn}) * co;
            ty_ff  <= $signed({1'b0, sn}) * si;
            sxm_ff <= csr.source_x * $signed({1'b0, m_ff});
            sym_ff <= csr.source_y * $signed({1'b0, m_ff});
         end
         G_MUL2: begin
            xt_ff       <= tx_ff * $signed({1'b0, csr.source_height});
            yt_ff       <= ty_ff * $signed({1'b0, csr.source_height});
            ohx_ff      <= csr.outer_half_x * m_ff;
            ohy_ff      <= csr.outer_half_y * m_ff;
            ihx_ff      <= csr.inner_half_x * m_ff;
            ihy_ff      <= csr.inner_half_y * m_ff;
            path_out_ff <= {h25, 15'b0} > 35'(m_ff * 22'(OUTER_PATH_NUM));
            path_in_ff  <= 31'({csr.source_height, 15'b0})
                           > 31'(csr.inner_min_path * m_ff);
         end
         G_CMP: begin
            outer_ff <= neg_ff && path_out_ff
                        && ax < 52'({ohx_ff, 15'b0}) && ay < 52'({ohy_ff, 15'b0});
            inner_ff <= neg_ff && path_out_ff
                        && ax < 52'({ohx_ff, 15'b0}) && ay < 52'({ohy_ff, 15'b0})
                        && path_in_ff
                        && ax < 52'({ihx_ff, 15'b0}) && ay < 52'({ihy_ff, 15'b0});
         end
         default: ;
      endcase
   end

   assign res.done  = done_ff;
   assign res.outer = outer_ff;
   assign res.inner = inner_ff;

endmodule

`default_nettype wire

FILE: rtl/ray_plane_acceptance_counter_top.sv
// ----------------------------------------------------------------------------
// Ray-plane acceptance counter
// An event beat traces a ray from the source to the detector plane, tests it
// against the scintillator and sensor rectangles, bumps the saturating
// counters and the cos-theta and azimuth histograms of each category hit.
// A read beat returns one entry of each histogram. After reset the block
// clears both histogram memories, one entry a cycle, over
// 3*max(POLAR_BINS, AZIMUTH_BINS) entries (300 by default) before taking a
// beat. An event runs 16 square root and CORDIC steps in the geometry unit,
// then its multiply and compare states G_MUL1, G_MUL2 and G_CMP, then a
// memory read state and a write state for each category hit. A result
// waits in an output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_plane_acceptance_counter_top_defines.svh"

module ray_plane_acceptance_counter_top import rpac_pkg::*; #(
   parameter int unsigned POLAR_BINS   = 100,
   parameter int unsigned AZIMUTH_BINS = 60,
   parameter int unsigned COUNT_WIDTH  = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cos_polar[15:0], azimuth[31:16], bin_select[40:32]
   input  wire logic [47:0]  req_tdata,
   // command[0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit_outer[0], hit_inner[1], event_total[33:2], outer_total[65:34],
   // inner_total[97:66], cos_bin_count[129:98], phi_bin_count[161:130]
   output logic [167:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [15:0]  csr_wdata
);

   localparam int unsigned P_DEPTH = 3 * POLAR_BINS;
   localparam int unsigned A_DEPTH = 3 * AZIMUTH_BINS;
   localparam int unsigned PA_W    = $clog2(P_DEPTH);
   localparam int unsigned AA_W    = $clog2(A_DEPTH);
   localparam int unsigned CLR_N   = (P_DEPTH > A_DEPTH) ? P_DEPTH : A_DEPTH;
   localparam int unsigned CL_W    = $clog2(CLR_N);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_GEO   = 4'd2;
   localparam logic [3:0] S_HRD   = 4'd3;
   localparam logic [3:0] S_HWR   = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_RDW   = 4'd6;
   localparam logic [3:0] S_DONE  = 4'd7;

   logic [3:0]             state_ff, state_in;
   csr_type                csr_ff;
   logic [CL_W-1:0]        clr_ff;
   logic                   cmd_ff;
   logic [8:0]             sel_ff;
   logic [PA_W-1:0]        pa_ff;
   logic [AA_W-1:0]        aa_ff;
   logic [1:0]             cat_ff, last_ff;
   logic                   outer_ff, inner_ff;
   logic [COUNT_WIDTH-1:0] ev_cnt_ff, out_cnt_ff, in_cnt_ff;
   logic [COUNT_WIDTH-1:0] cosv_ff, phiv_ff;
   logic                   rsp_tvalid_ff;
   logic [167:0]           rsp_data_ff;

   logic [COUNT_WIDTH-1:0] pol_mem [P_DEPTH];
   logic [COUNT_WIDTH-1:0] az_mem  [A_DEPTH];
   logic [COUNT_WIDTH-1:0] pol_rd_ff, az_rd_ff;

   logic                   accept, geo_start, load;
   logic signed [15:0]     in_cos, in_az;
   logic [24:0]            pprod, aprod;
   geom_res_type           geo;
   logic                   pw_en, aw_en, mem_re;
   logic [PA_W-1:0]        pw_addr, pr_addr;
   logic [AA_W-1:0]        aw_addr, ar_addr;
   logic [COUNT_WIDTH-1:0] pw_data, aw_data;
   logic                   sel_p_ok, sel_a_ok;

   assign in_cos     = req_tdata[15:0];
   assign in_az      = req_tdata[31:16];
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign geo_start  = accept && !req_tuser[0];
   assign load       = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);
   assign pprod      = 25'($unsigned(in_cos) ^ 16'h8000) * 25'(POLAR_BINS);
   assign aprod      = 25'($unsigned(in_az) ^ 16'h8000) * 25'(AZIMUTH_BINS);
   assign sel_p_ok   = 32'(sel_ff) < 32'(P_DEPTH);
   assign sel_a_ok   = 32'(sel_ff) < 32'(A_DEPTH);

   rpac_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .start     (geo_start),
      .cos_polar (in_cos),
      .azimuth   (in_az),
      .csr       (csr_ff),
      .res       (geo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.source_x       <= '0;
         csr_ff.source_y       <= '0;
         csr_ff.source_height  <= 15'd5120;
         csr_ff.outer_half_x   <= 15'd3584;
         csr_ff.outer_half_y   <= 15'd3584;
         csr_ff.inner_half_x   <= 15'd2560;
         csr_ff.inner_half_y   <= 15'd1510;
         csr_ff.inner_min_path <= 15'd771;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SOURCE_X:      csr_ff.source_x       <= csr_wdata;
            CSR_SOURCE_Y:      csr_ff.source_y       <= csr_wdata;
            CSR_SOURCE_HEIGHT: csr_ff.source_height  <= csr_wdata[14:0];
            CSR_OUTER_HALF_X:  csr_ff.outer_half_x   <= csr_wdata[14:0];
            CSR_OUTER_HALF_Y:  csr_ff.outer_half_y   <= csr_wdata[14:0];
            CSR_INNER_HALF_X:  csr_ff.inner_half_x   <= csr_wdata[14:0];
            CSR_INNER_HALF_Y:  csr_ff.inner_half_y   <= csr_wdata[14:0];
            CSR_INNER_MIN:     csr_ff.inner_min_path <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == CL_W'(CLR_N - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept) state_in = req_tuser[0] ? S_RD : S_GEO;
         S_GEO:   if (geo.done) state_in = S_HRD;
         S_HRD:   state_in = S_HWR;
         S_HWR:   state_in = (cat_ff == last_ff) ? S_DONE : S_HRD;
         S_RD:    state_in = S_RDW;
         S_RDW:   state_in = S_DONE;
         S_DONE:  if (load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      pw_en   = 1'b0;
      aw_en   = 1'b0;
      pw_addr = pa_ff;
      aw_addr = aa_ff;
      pw_data = (&pol_rd_ff) ? pol_rd_ff : pol_rd_ff + 1'b1;
      aw_data = (&az_rd_ff) ? az_rd_ff : az_rd_ff + 1'b1;
      mem_re  = 1'b0;
      pr_addr = pa_ff;
      ar_addr = aa_ff;
      case (state_ff)
         S_CLEAR: begin
            pw_en   = 32'(clr_ff) < 32'(P_DEPTH);
            aw_en   = 32'(clr_ff) < 32'(A_DEPTH);
            pw_addr = PA_W'(clr_ff);
            aw_addr = AA_W'(clr_ff);
            pw_data = '0;
            aw_data = '0;
         end
         S_HRD: mem_re = 1'b1;
         S_HWR: begin
            pw_en = 1'b1;
            aw_en = 1'b1;
         end
         S_RD: begin
            mem_re  = 1'b1;
            pr_addr = PA_W'(sel_ff);
            ar_addr = AA_W'(sel_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pw_en) pol_mem[pw_addr] <= pw_data;
      if (aw_en) az_mem[aw_addr] <= aw_data;
      if (mem_re) begin
         pol_rd_ff <= pol_mem[pr_addr];
         az_rd_ff  <= az_mem[ar_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         ev_cnt_ff     <= '0;
         out_cnt_ff    <= '0;
         in_cnt_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == S_GEO && geo.done) begin
            if (!(&ev_cnt_ff)) ev_cnt_ff <= ev_cnt_ff + 1'b1;
            if (geo.outer && !(&out_cnt_ff)) out_cnt_ff <= out_cnt_ff + 1'b1;
            if (geo.inner && !(&in_cnt_ff)) in_cnt_ff <= in_cnt_ff + 1'b1;
         end
         if (load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_tuser[0];
         sel_ff   <= req_tdata[40:32];
         pa_ff    <= PA_W'(pprod >> 16);
         aa_ff    <= AA_W'(aprod >> 16);
         cat_ff   <= '0;
         outer_ff <= 1'b0;
         inner_ff <= 1'b0;
         cosv_ff  <= '0;
         phiv_ff  <= '0;
      end
      if (state_ff == S_GEO && geo.done) begin
         outer_ff <= geo.outer;
         inner_ff <= geo.inner;
         last_ff  <= geo.inner ? 2'd2 : (geo.outer ? 2'd1 : 2'd0);
      end
      if (state_ff == S_HWR) begin
         cat_ff <= cat_ff + 2'd1;
         pa_ff  <= pa_ff + PA_W'(POLAR_BINS);
         aa_ff  <= aa_ff + AA_W'(AZIMUTH_BINS);
      end
      if (state_ff == S_RDW) begin
         cosv_ff <= sel_p_ok ? pol_rd_ff : '0;
         phiv_ff <= sel_a_ok ? az_rd_ff : '0;
      end
      if (load) begin
         rsp_data_ff <= {6'b0, 32'(phiv_ff), 32'(cosv_ff), 32'(in_cnt_ff),
                         32'(out_cnt_ff), 32'(ev_cnt_ff),
                         inner_ff && !cmd_ff, outer_ff && !cmd_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `RPAC_ASSERT_NOW(a_inner_le_outer, clock, reset, 1'b1,
      in_cnt_ff <= out_cnt_ff, "inner count above outer count")
   `RPAC_ASSERT_NEXT(a_events_monotonic, clock, reset, state_ff != S_CLEAR,
      ev_cnt_ff >= $past(ev_cnt_ff), "event count went down")
   `RPAC_ASSERT_NOW(a_result_from_done, clock, reset, $rose(rsp_tvalid_ff),
      $past(state_ff == S_DONE), "result raised outside completion")

endmodule

`default_nettype wire
